// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the timer project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLY(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(lbl, ck, a, b) \
  lbl: assert property (@(posedge ck) (a) |=> (b)) \
    else $error("reset behavior check failed");

`endif

// ----- rtl/core/mcpt_pkg.sv -----
// Package of the multi-channel periodic timer: sizes, codes and the request queue entry.
// Depends on nothing; used by every module of the timer but mcpt_ram.
`default_nettype none

package mcpt_pkg;

  // Channel bank sizing; ids are four bits wide, so at most 16 channels are usable.
  localparam int CHANNELS = 16;
  localparam int ID_LIMIT = 16;
  localparam int CAPACITY = (CHANNELS < ID_LIMIT) ? CHANNELS : ID_LIMIT;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [4:0] CAPACITY_C = 5'(CAPACITY);

  // Request queue between front and back.
  localparam int QDEPTH = 2;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_TICK_PREC = 3'd0;
  localparam logic [15:0] TICK_PREC_RESET = 16'd1;

  // Command codes.
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_CHANGE = 3'd2;
  localparam logic [2:0] CMD_TRIG   = 3'd3;
  localparam logic [2:0] CMD_START  = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_ADDED  = 3'd1;
  localparam logic [2:0] ST_FIRED  = 3'd2;
  localparam logic [2:0] ST_BAD_ID = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  // Classified operation handed from front to back.
  typedef enum logic [2:0] {
    OP_TICK,
    OP_ADD,
    OP_FULL,
    OP_CHANGE,
    OP_TRIG,
    OP_BAD,
    OP_START,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  chan;
    logic [30:0] period;
    logic [30:0] delay;
    logic [4:0]  cnt;
  } qent_t;

endpackage

`default_nettype wire

// ----- rtl/core/mcpt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module mcpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/mcpt_front.sv -----
// Front end of the timer: accepts requests, classifies them and queues them.
// Depends on mcpt_pkg.
`default_nettype none

module mcpt_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [2:0]    in_cmd,
  input  wire logic [3:0]    in_channel,
  input  wire logic [30:0]   in_period_ms,
  input  wire logic [30:0]   in_delay_ms,
  input  wire logic          pop,
  output logic               q_valid,
  output mcpt_pkg::qent_t    q_head
);
  import mcpt_pkg::*;

  logic [4:0] count_r, count_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  qent_t      q_r [QDEPTH];
  qent_t      ent;
  logic       accept;
  logic       id_ok;

  assign busy    = (q_cnt_r == 2'(QDEPTH));
  assign accept  = start && !busy;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_head  = q_r[rd_ptr_r];
  assign id_ok   = ({1'b0, in_channel} < count_r);

  // Classify the request against the channel count seen so far.
  always_comb begin
    ent        = '0;
    ent.op     = OP_NOP;
    ent.period = in_period_ms;
    ent.delay  = in_delay_ms;
    ent.cnt    = count_r;
    count_nxt  = count_r;
    case (in_cmd)
      CMD_TICK: begin
        ent.op = OP_TICK;
      end
      CMD_ADD: begin
        if (count_r >= CAPACITY_C) begin
          ent.op = OP_FULL;
        end else begin
          ent.op    = OP_ADD;
          ent.chan  = count_r[3:0];
          count_nxt = count_r + 5'd1;
        end
      end
      CMD_CHANGE: begin
        ent.chan = in_channel;
        ent.op   = id_ok ? OP_CHANGE : OP_BAD;
      end
      CMD_TRIG: begin
        ent.chan = in_channel;
        ent.op   = id_ok ? OP_TRIG : OP_BAD;
      end
      CMD_START: begin
        ent.op = OP_START;
      end
      default: begin
        ent.op = OP_NOP;
      end
    endcase
  end

  // Queue pointer and occupancy updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (accept) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (accept && !pop) begin
      q_cnt_nxt = q_cnt_r + 2'd1;
    end else if (!accept && pop) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      q_cnt_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      q_cnt_r  <= q_cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= ent;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mcpt_back.sv -----
// Back end of the timer: executes queued requests against the channel tables.
// Depends on mcpt_pkg and mcpt_ram.
`default_nettype none

module mcpt_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [15:0]   tick_prec,
  input  wire logic          q_valid,
  input  mcpt_pkg::qent_t    q_head,
  output logic               pop,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [3:0]         out_channel_id,
  output logic               out_last
);
  import mcpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_TRIG = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  qent_t       cur_r, cur_nxt;
  logic [31:0] time_r, time_nxt;
  logic [4:0]  rd_idx_r, rd_idx_nxt;
  logic        p_v_r, p_v_nxt;
  logic [3:0]  p_idx_r, p_idx_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [3:0]  pend_id_r, pend_id_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [3:0]  oid_r, oid_nxt;
  logic        olast_r, olast_nxt;

  // Table ports.
  logic             per_we, dly_we, lst_we;
  logic [IDX_W-1:0] per_waddr, lst_waddr, raddr;
  logic [30:0]      per_wdata, per_rdata, dly_rdata;
  logic [31:0]      lst_wdata, lst_rdata;
  logic [31:0]      diff;
  logic             due;

  mcpt_ram #(.WIDTH(31), .DEPTH(CAPACITY)) u_period (
    .clk(clk), .we(per_we), .waddr(per_waddr), .wdata(per_wdata),
    .raddr(raddr), .rdata(per_rdata)
  );

  mcpt_ram #(.WIDTH(31), .DEPTH(CAPACITY)) u_delay (
    .clk(clk), .we(dly_we), .waddr(per_waddr), .wdata(cur_r.delay),
    .raddr(raddr), .rdata(dly_rdata)
  );

  mcpt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_last (
    .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
    .raddr(raddr), .rdata(lst_rdata)
  );

  // Read address: the queued channel while idle, the scan index while scanning.
  assign raddr = (state_r == S_SCAN) ? rd_idx_r[IDX_W-1:0] : q_head.chan[IDX_W-1:0];

  // Due test for the channel whose table words arrived this cycle.
  assign diff = time_r - lst_rdata;
  assign due  = (per_rdata != 31'd0) && !diff[31] && (diff[30:0] >= per_rdata);

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    time_nxt    = time_r;
    rd_idx_nxt  = rd_idx_r;
    p_v_nxt     = 1'b0;
    p_idx_nxt   = p_idx_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    pop         = 1'b0;
    ov_nxt      = 1'b0;
    ost_nxt     = ST_OK;
    oid_nxt     = 4'd0;
    olast_nxt   = 1'b1;
    per_we      = 1'b0;
    dly_we      = 1'b0;
    lst_we      = 1'b0;
    per_waddr   = cur_r.chan[IDX_W-1:0];
    per_wdata   = cur_r.period;
    lst_waddr   = cur_r.chan[IDX_W-1:0];
    lst_wdata   = time_r - {1'b0, cur_r.period};
    case (state_r)
      // Take the next request from the queue.
      S_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          cur_nxt    = q_head;
          rd_idx_nxt = '0;
          pend_v_nxt = 1'b0;
          case (q_head.op)
            OP_TICK: begin
              time_nxt  = time_r + {16'd0, tick_prec};
              state_nxt = S_SCAN;
            end
            OP_START: state_nxt = S_SCAN;
            OP_TRIG:  state_nxt = S_TRIG;
            default:  state_nxt = S_EXEC;
          endcase
        end
      end
      // Single-step requests.
      S_EXEC: begin
        ov_nxt    = 1'b1;
        oid_nxt   = cur_r.chan;
        state_nxt = S_IDLE;
        case (cur_r.op)
          OP_ADD: begin
            per_we  = 1'b1;
            dly_we  = 1'b1;
            lst_we  = 1'b1;
            ost_nxt = ST_ADDED;
          end
          OP_CHANGE: begin
            per_we = 1'b1;
          end
          OP_BAD:  ost_nxt = ST_BAD_ID;
          OP_FULL: ost_nxt = ST_FULL;
          default: ost_nxt = ST_OK;
        endcase
      end
      // Trigger now: the channel's period has been read.
      S_TRIG: begin
        lst_we    = 1'b1;
        lst_wdata = time_r - {1'b0, per_rdata};
        ov_nxt    = 1'b1;
        oid_nxt   = cur_r.chan;
        state_nxt = S_IDLE;
      end
      // Scan channels in order: read one, evaluate the one read before.
      S_SCAN: begin
        if (rd_idx_r < cur_r.cnt) begin
          p_v_nxt    = 1'b1;
          p_idx_nxt  = rd_idx_r[3:0];
          rd_idx_nxt = rd_idx_r + 5'd1;
        end
        lst_waddr = p_idx_r[IDX_W-1:0];
        if (p_v_r) begin
          if (cur_r.op == OP_START) begin
            lst_we    = 1'b1;
            lst_wdata = time_r - {1'b0, per_rdata} + {1'b0, dly_rdata};
          end else if (due) begin
            lst_we      = 1'b1;
            lst_wdata   = time_r;
            pend_v_nxt  = 1'b1;
            pend_id_nxt = p_idx_r;
            // A new firing releases the one held back, which is not last.
            if (pend_v_r) begin
              ov_nxt    = 1'b1;
              ost_nxt   = ST_FIRED;
              oid_nxt   = pend_id_r;
              olast_nxt = 1'b0;
            end
          end
        end else if (rd_idx_r >= cur_r.cnt) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          if ((cur_r.op == OP_TICK) && pend_v_r) begin
            ost_nxt = ST_FIRED;
            oid_nxt = pend_id_r;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      time_r   <= '0;
      p_v_r    <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      time_r   <= time_nxt;
      p_v_r    <= p_v_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    rd_idx_r  <= rd_idx_nxt;
    p_idx_r   <= p_idx_nxt;
    pend_id_r <= pend_id_nxt;
    ost_r     <= ost_nxt;
    oid_r     <= oid_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_status     = ost_r;
  assign out_channel_id = oid_r;
  assign out_last       = olast_r;

endmodule

`default_nettype wire

// ----- rtl/core/multi_channel_periodic_timer_unit.sv -----
// Top level of the multi-channel periodic timer: configuration register and front/back.
// Depends on mcpt_pkg, mcpt_front and mcpt_back.
`default_nettype none

// Usage:
// A request is taken at a rising edge where start is high and busy is low. It
// carries in_cmd (tick, add channel, change period, trigger now, start),
// in_channel, in_period_ms and in_delay_ms. The front end classifies it and
// places it in a two-entry queue, so busy rises only when that queue is full.
// Results appear on out_status, out_channel_id and out_last for one cycle each,
// marked by out_valid; the receiver cannot hold them off. A tick gives one
// result per firing channel, or one ok result if none fires; every other
// request gives exactly one result. out_last marks the final one.
// Add, change period, trigger now and unknown requests take the back end from
// idle through their execute state and back to idle. Tick and start scan the
// N added channels one per cycle through the table read ports, and the final
// result follows the evaluation of the last channel.
// The tick precision register lies at byte address 0 of the APB port
// (psel, penable, pwrite, paddr, pwdata, prdata, pready; pready always high).
// Reset clears the clock, the channel count and the queue, and sets the
// precision to 1 ms. The channel tables need no clearing pass.
module multi_channel_periodic_timer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_cmd,
  input  wire logic [3:0]                    in_channel,
  input  wire logic [30:0]                   in_period_ms,
  input  wire logic [30:0]                   in_delay_ms,
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output logic [3:0]                         out_channel_id,
  output logic                               out_last,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mcpt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import mcpt_pkg::*;

  logic [15:0] tick_prec_r;
  logic        cfg_wr;
  logic        q_valid;
  logic        pop;
  qent_t       q_head;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_TICK_PREC);
  assign prdata = (paddr == ADDR_TICK_PREC) ? {16'd0, tick_prec_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_prec_r <= TICK_PREC_RESET;
    end else if (cfg_wr) begin
      tick_prec_r <= pwdata[15:0];
    end
  end

  mcpt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_channel   (in_channel),
    .in_period_ms (in_period_ms),
    .in_delay_ms  (in_delay_ms),
    .pop          (pop),
    .q_valid      (q_valid),
    .q_head       (q_head)
  );

  mcpt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_prec      (tick_prec_r),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_channel_id (out_channel_id),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/mcpt_checker.sv -----
// Port-level checks of the multi-channel periodic timer, bound to its top level.
// Depends on mcpt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mcpt_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          busy,
  input  wire logic                          out_valid,
  input  wire logic [2:0]                    out_status,
  input  wire logic                          out_last,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mcpt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  input  wire logic [31:0]                   prdata,
  input  wire logic                          pready
);
  import mcpt_pkg::*;

  logic        prec_wr;
  logic        prec_seen;
  logic [15:0] prec_wdata_r;

  // A precision write, and whether the read port shows the data written in the previous cycle.
  assign prec_wr   = psel && penable && pwrite && pready && (paddr == ADDR_TICK_PREC);
  assign prec_seen = (paddr != ADDR_TICK_PREC) || (prdata[15:0] == prec_wdata_r);

  // Write data of the previous cycle.
  always_ff @(posedge clk) begin
    prec_wdata_r <= pwdata[15:0];
  end

  // Reset empties the result register and the request queue.
  `ASSERT_NEXT_ALWAYS(a_rst_no_result, clk, !rst_n, !out_valid)
  `ASSERT_NEXT_ALWAYS(a_rst_not_busy, clk, !rst_n, !busy)

  // Only fire results of a tick can be followed by more results of the same request.
  `ASSERT_IMPLY(a_nonlast_fired, clk, rst_n, out_valid && !out_last, out_status == ST_FIRED)

  // A precision write is visible on the read port in the next cycle.
  `ASSERT_NEXT(a_cfg_readback, clk, rst_n, prec_wr, prec_seen)

endmodule

bind multi_channel_periodic_timer_unit mcpt_checker u_mcpt_checker (.*);

`default_nettype wire
